// ===== rtl/rst_pkg.sv =====
// Shared types and codes for the retransmit slot table.
package rst_pkg;

    localparam logic [1:0] CMD_QUEUE = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [2:0] KIND_SEND   = 3'd0;
    localparam logic [2:0] KIND_QSTAT  = 3'd1;
    localparam logic [2:0] KIND_ASTAT  = 3'd2;
    localparam logic [2:0] KIND_NOROUTE = 3'd3;
    localparam logic [2:0] KIND_GAVEUP = 3'd4;
    localparam logic [2:0] KIND_TDONE  = 3'd5;

    localparam logic [1:0] REG_INTERVAL = 2'd0;
    localparam logic [1:0] REG_TRIES    = 2'd1;
    localparam logic [1:0] REG_PAYLOAD  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QSCAN,
        ST_QWRITE,
        ST_QSEND,
        ST_QSTAT,
        ST_ASCAN,
        ST_ASTAT,
        ST_TRD,
        ST_TEVAL,
        ST_TOUT,
        ST_TDONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       clr_idx;
        logic       inc_idx;
        logic       latch_in;
        logic       q_search;
        logic       q_commit;
        logic       a_search;
        logic       a_clear;
        logic       t_start;
        logic       t_read;
        logic       t_commit;
        logic       load_out;
        logic [2:0] out_kind;
        logic       out_ok;
        logic       out_entry;
        logic       out_ackseq;
        logic       out_last;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       idx_last;
        logic       found;
        logic       q_reject;
        logic       q_route;
        logic       t_active;
        logic [2:0] t_kind;
        logic       out_full;
    } t_stat;

endpackage

// ===== rtl/rst_ctrl.sv =====
// Controller state machine for the retransmit slot table.
module rst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_command,
    output logic           o_ready,
    input  rst_pkg::t_stat i_stat,
    output rst_pkg::t_cmd  o_cmd
);

    rst_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rst_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rst_pkg::ST_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        rst_pkg::CMD_QUEUE: n_state = rst_pkg::ST_QSCAN;
                        rst_pkg::CMD_ACK:   n_state = rst_pkg::ST_ASCAN;
                        rst_pkg::CMD_TICK:  n_state = rst_pkg::ST_TRD;
                        default:            n_state = rst_pkg::ST_IDLE;
                    endcase
                end
            end
            rst_pkg::ST_QSCAN: begin
                if (i_stat.q_reject) begin
                    n_state = rst_pkg::ST_QSTAT;
                end else if (i_stat.found || i_stat.idx_last) begin
                    n_state = rst_pkg::ST_QWRITE;
                end
            end
            rst_pkg::ST_QWRITE: begin
                n_state = i_stat.q_route ? rst_pkg::ST_QSEND : rst_pkg::ST_QSTAT;
            end
            rst_pkg::ST_QSEND: begin
                if (!i_stat.out_full) n_state = rst_pkg::ST_QSTAT;
            end
            rst_pkg::ST_QSTAT: begin
                if (!i_stat.out_full) n_state = rst_pkg::ST_IDLE;
            end
            rst_pkg::ST_ASCAN: begin
                if (i_stat.found || i_stat.idx_last) n_state = rst_pkg::ST_ASTAT;
            end
            rst_pkg::ST_ASTAT: begin
                if (!i_stat.out_full) n_state = rst_pkg::ST_IDLE;
            end
            rst_pkg::ST_TRD:   n_state = rst_pkg::ST_TEVAL;
            rst_pkg::ST_TEVAL: begin
                if (i_stat.t_active) begin
                    n_state = rst_pkg::ST_TOUT;
                end else if (i_stat.idx_last) begin
                    n_state = rst_pkg::ST_TDONE;
                end else begin
                    n_state = rst_pkg::ST_TRD;
                end
            end
            rst_pkg::ST_TOUT: begin
                if (!i_stat.out_full) begin
                    n_state = i_stat.idx_last ? rst_pkg::ST_TDONE : rst_pkg::ST_TRD;
                end
            end
            rst_pkg::ST_TDONE: begin
                if (!i_stat.out_full) n_state = rst_pkg::ST_IDLE;
            end
            default: n_state = rst_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            rst_pkg::ST_IDLE: begin
                o_ready         = 1'b1;
                o_cmd.clr_idx   = 1'b1;
                o_cmd.latch_in  = i_valid;
                o_cmd.t_start   = i_valid && (i_command == rst_pkg::CMD_TICK);
            end
            rst_pkg::ST_QSCAN: begin
                o_cmd.q_search = 1'b1;
                o_cmd.inc_idx  = !i_stat.found && !i_stat.idx_last;
            end
            rst_pkg::ST_QWRITE: o_cmd.q_commit = 1'b1;
            rst_pkg::ST_QSEND: begin
                o_cmd.load_out  = !i_stat.out_full;
                o_cmd.out_kind  = rst_pkg::KIND_SEND;
                o_cmd.out_entry = 1'b1;
            end
            rst_pkg::ST_QSTAT: begin
                o_cmd.load_out  = !i_stat.out_full;
                o_cmd.out_kind  = rst_pkg::KIND_QSTAT;
                o_cmd.out_entry = !i_stat.q_reject;
                o_cmd.out_ok    = i_stat.q_route && !i_stat.q_reject;
                o_cmd.out_last  = 1'b1;
            end
            rst_pkg::ST_ASCAN: begin
                o_cmd.a_search = 1'b1;
                o_cmd.inc_idx  = !i_stat.found && !i_stat.idx_last;
            end
            rst_pkg::ST_ASTAT: begin
                o_cmd.load_out   = !i_stat.out_full;
                o_cmd.a_clear    = !i_stat.out_full && i_stat.found;
                o_cmd.out_kind   = rst_pkg::KIND_ASTAT;
                o_cmd.out_entry  = i_stat.found;
                o_cmd.out_ackseq = !i_stat.found;
                o_cmd.out_ok     = i_stat.found;
                o_cmd.out_last   = 1'b1;
            end
            rst_pkg::ST_TRD: o_cmd.t_read = 1'b1;
            rst_pkg::ST_TEVAL: begin
                o_cmd.inc_idx = !i_stat.t_active && !i_stat.idx_last;
            end
            rst_pkg::ST_TOUT: begin
                o_cmd.load_out  = !i_stat.out_full;
                o_cmd.t_commit  = !i_stat.out_full;
                o_cmd.inc_idx   = !i_stat.out_full && !i_stat.idx_last;
                o_cmd.out_kind  = i_stat.t_kind;
                o_cmd.out_entry = 1'b1;
            end
            rst_pkg::ST_TDONE: begin
                o_cmd.load_out = !i_stat.out_full;
                o_cmd.out_kind = rst_pkg::KIND_TDONE;
                o_cmd.out_last = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/rst_datapath.sv =====
// Slot table storage, search, timer compare and output register.
module rst_datapath #(
    parameter int SLOTS     = 48,
    parameter int MAX_SEATS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rst_pkg::t_cmd  i_cmd,
    output rst_pkg::t_stat o_stat,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  logic [9:0]     i_payload_length,
    input  logic [15:0]    i_payload_ref,
    input  logic           i_dest_is_seat,
    input  logic [15:0]    i_dest_id,
    input  logic [31:0]    i_ack_seq,
    input  logic [15:0]    i_peer_present_mask,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_kind,
    output logic [5:0]     o_slot,
    output logic [31:0]    o_seq_out,
    output logic           o_out_is_seat,
    output logic [15:0]    o_out_dest,
    output logic [15:0]    o_out_payload_ref,
    output logic [9:0]     o_out_length,
    output logic           o_ok,
    output logic           o_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // entry word: seq, due, tries, is_seat, dest, ref, len
    localparam int EW = 32 + 32 + 8 + 1 + 16 + 16 + 10;
    logic [EW-1:0] r_mem [SLOTS];
    logic [EW-1:0] r_rd;
    logic [SLOTS-1:0] r_valid;

    logic [15:0] r_interval;
    logic [7:0]  r_max_tries;
    logic [9:0]  r_max_payload;
    logic [31:0] r_last_seq;
    logic [IW-1:0] r_last_mod;
    logic [31:0] r_now;

    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_slot;
    logic          r_found;
    logic [9:0]    r_len;
    logic [15:0]   r_ref;
    logic          r_seat;
    logic [15:0]   r_dest;
    logic [31:0]   r_ack;
    logic [15:0]   r_mask;
    logic [31:0]   r_seq_new;
    logic          r_t_active;
    logic [2:0]    r_t_kind;
    logic [IW-1:0] r_mod;
    logic          r_eval;

    logic [31:0] rd_seq, rd_due;
    logic [7:0]  rd_tries;
    logic        rd_seat;
    logic [15:0] rd_dest, rd_ref;
    logic [9:0]  rd_len;

    assign {rd_seq, rd_due, rd_tries, rd_seat, rd_dest, rd_ref, rd_len} = r_rd;

    function automatic logic route(input logic seat, input logic [15:0] dest,
                                   input logic [15:0] mask);
        logic r;
        r = 1'b1;
        if (seat) begin
            if (dest >= 16'(MAX_SEATS)) r = 1'b0;
            else r = mask[dest[3:0]];
        end
        return r;
    endfunction

    logic q_reject, q_route, idx_last;
    logic [31:0] seq_next;
    logic [IW-1:0] mod_next;
    logic [IW-1:0] idx_next;
    logic [31:0] due_diff;
    logic        eval_due, eval_route;
    logic [2:0]  eval_kind;

    assign q_reject = (r_len == 10'd0) || (r_len > r_max_payload);
    assign q_route  = route(r_seat, r_dest, r_mask);
    assign idx_last = (r_idx == LAST_IDX);
    assign seq_next = ((r_last_seq + 32'd1) == 32'd0) ? 32'd1 : r_last_seq + 32'd1;
    // residue of the sequence kept alongside it; the skipped zero restarts it at one
    assign mod_next = (r_last_seq == '1) ? IW'(1) :
                      ((r_last_mod == LAST_IDX) ? '0 : r_last_mod + IW'(1));
    assign idx_next = i_cmd.clr_idx ? '0 : (i_cmd.inc_idx ? r_idx + IW'(1) : r_idx);
    assign due_diff = r_now - rd_due;
    assign eval_due = r_valid[r_idx] && !due_diff[31];
    assign eval_route = route(rd_seat, rd_dest, r_mask);

    always_comb begin
        if (!eval_route)                  eval_kind = rst_pkg::KIND_NOROUTE;
        else if (rd_tries >= r_max_tries) eval_kind = rst_pkg::KIND_GAVEUP;
        else                              eval_kind = rst_pkg::KIND_SEND;
    end

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval    <= 16'd220;
            r_max_tries   <= 8'd16;
            r_max_payload <= 10'd599;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rst_pkg::REG_INTERVAL: r_interval    <= i_cfg_data;
                rst_pkg::REG_TRIES:    r_max_tries   <= i_cfg_data[7:0];
                rst_pkg::REG_PAYLOAD:  r_max_payload <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // input latch and scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_len  <= i_payload_length;
            r_ref  <= i_payload_ref;
            r_seat <= i_dest_is_seat;
            r_dest <= i_dest_id;
            r_ack  <= i_ack_seq;
            r_mask <= i_peer_present_mask;
        end
        if (i_cmd.clr_idx) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_mod   <= '0;
        end else if (i_cmd.inc_idx) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.q_search) begin
            r_seq_new <= seq_next;
            r_mod     <= mod_next;
            if (!r_valid[r_idx]) begin
                r_found <= 1'b1;
                r_slot  <= r_idx;
            end
        end
        if (i_cmd.a_search && r_valid[r_idx] && r_ack != 32'd0 && rd_seq == r_ack) begin
            r_found <= 1'b1;
            r_slot  <= r_idx;
        end
        if (i_cmd.q_commit && !r_found) r_slot <= r_mod;
        if (i_cmd.t_read) r_slot <= r_idx;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_last_seq <= '0;
            r_last_mod <= '0;
            r_now      <= '0;
            r_t_active <= 1'b0;
            r_t_kind   <= rst_pkg::KIND_SEND;
        end else begin
            if (i_cmd.t_start) r_now <= r_now + 32'd1;
            if (i_cmd.q_commit) begin
                r_last_seq <= r_seq_new;
                r_last_mod <= r_mod;
                r_valid[r_found ? r_slot : r_mod] <= 1'b1;
            end
            if (i_cmd.a_clear) r_valid[r_slot] <= 1'b0;
            if (i_cmd.t_read) r_t_active <= 1'b0;
            if (i_cmd.inc_idx) r_t_active <= 1'b0;
            if (i_cmd.t_commit && r_t_kind != rst_pkg::KIND_SEND) begin
                r_valid[r_slot] <= 1'b0;
            end
            // evaluation of the slot just read
            if (r_eval) begin
                r_t_active <= eval_due;
                r_t_kind   <= eval_kind;
            end
        end
    end

    // one-cycle flag: the cycle after a read is the evaluate state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_eval <= 1'b0;
        else          r_eval <= i_cmd.t_read;
    end

    // memory: one read port, one write port
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_slot;
        mem_wd = r_rd;
        if (i_cmd.q_commit) begin
            mem_we = 1'b1;
            mem_wa = r_found ? r_slot : r_mod;
            mem_wd = {r_seq_new, q_route ? r_now + {16'd0, r_interval} : r_now,
                      q_route ? 8'd1 : 8'd0, r_seat, r_dest, r_ref, r_len};
        end else if (i_cmd.t_commit && r_t_kind == rst_pkg::KIND_SEND) begin
            mem_we = 1'b1;
            mem_wd = {rd_seq, r_now + {16'd0, r_interval}, rd_tries + 8'd1,
                      rd_seat, rd_dest, rd_ref, rd_len};
        end
    end

    // scans read ahead at the next index so the data lines up with r_idx
    logic [IW-1:0] mem_ra;
    assign mem_ra = (i_cmd.q_commit || i_cmd.a_clear || i_cmd.out_entry) ? r_slot : idx_next;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (!i_cmd.out_entry || i_cmd.q_commit) r_rd <= r_mem[mem_ra];
        if (mem_we && i_cmd.q_commit) r_rd <= mem_wd;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_kind            <= i_cmd.out_kind;
            o_ok              <= i_cmd.out_ok;
            o_last            <= i_cmd.out_last;
            o_slot            <= i_cmd.out_entry ? 6'(r_slot) : 6'd0;
            o_seq_out         <= i_cmd.out_entry ? rd_seq :
                                 (i_cmd.out_ackseq ? r_ack : 32'd0);
            o_out_is_seat     <= i_cmd.out_entry ? rd_seat : 1'b0;
            o_out_dest        <= i_cmd.out_entry ? rd_dest : 16'd0;
            o_out_payload_ref <= i_cmd.out_entry ? rd_ref : 16'd0;
            o_out_length      <= i_cmd.out_entry ? rd_len : 10'd0;
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.idx_last = idx_last;
        o_stat.found    = i_cmd.q_search ? !r_valid[r_idx] :
                          (i_cmd.a_search ? (r_valid[r_idx] && r_ack != 32'd0 &&
                                             rd_seq == r_ack) : r_found);
        o_stat.q_reject = q_reject;
        o_stat.q_route  = q_route;
        o_stat.t_active = r_eval ? eval_due : r_t_active;
        o_stat.t_kind   = r_eval ? eval_kind : r_t_kind;
        o_stat.out_full = o_valid && !i_ready;
    end

endmodule

// ===== rtl/retransmit_slot_table_unit.sv =====
// Top level of the retransmit slot table.
// Queue, ack and tick commands each scan the slot memory in index order. One item at a time.
// Results leave through a one-deep output register, held under backpressure.
// Synchronous reset clears valid bits, sequence, time and registers to defaults.
module retransmit_slot_table_unit #(
    parameter int SLOTS     = 48,
    parameter int MAX_SEATS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_payload_length,
    input  logic [15:0] i_payload_ref,
    input  logic        i_dest_is_seat,
    input  logic [15:0] i_dest_id,
    input  logic [31:0] i_ack_seq,
    input  logic [15:0] i_peer_present_mask,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [5:0]  o_slot,
    output logic [31:0] o_seq_out,
    output logic        o_out_is_seat,
    output logic [15:0] o_out_dest,
    output logic [15:0] o_out_payload_ref,
    output logic [9:0]  o_out_length,
    output logic        o_ok,
    output logic        o_last
);

    rst_pkg::t_cmd  cmd;
    rst_pkg::t_stat stat;

    rst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    rst_datapath #(.SLOTS(SLOTS), .MAX_SEATS(MAX_SEATS)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_payload_length    (i_payload_length),
        .i_payload_ref       (i_payload_ref),
        .i_dest_is_seat      (i_dest_is_seat),
        .i_dest_id           (i_dest_id),
        .i_ack_seq           (i_ack_seq),
        .i_peer_present_mask (i_peer_present_mask),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_kind              (o_kind),
        .o_slot              (o_slot),
        .o_seq_out           (o_seq_out),
        .o_out_is_seat       (o_out_is_seat),
        .o_out_dest          (o_out_dest),
        .o_out_payload_ref   (o_out_payload_ref),
        .o_out_length        (o_out_length),
        .o_ok                (o_ok),
        .o_last              (o_last)
    );

endmodule

// ===== sim/retransmit_slot_table_unit_tb.sv =====
// Self-checking testbench for the retransmit slot table unit.
`timescale 1ns / 100ps

module retransmit_slot_table_unit_tb;

    localparam int SLOTS = 48;
    localparam int MAX_SEATS = 16;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  length;
        logic [15:0] pref;
        logic        is_seat;
        logic [15:0] dest;
        logic [31:0] ack_seq;
        logic [15:0] mask;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  slot;
        logic [31:0] seq;
        logic        is_seat;
        logic [15:0] dest;
        logic [15:0] pref;
        logic [9:0]  length;
        logic        ok;
        logic        last;
    } t_result;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    t_item       in_item;
    logic        out_valid;
    logic        out_ready;
    t_result     out_res;

    // predictor state
    logic [15:0] tbl_interval;
    logic [7:0]  tbl_max_tries;
    logic [9:0]  tbl_max_len;
    logic        tbl_valid [SLOTS];
    logic [31:0] tbl_seq [SLOTS];
    logic [31:0] tbl_due [SLOTS];
    logic [7:0]  tbl_tries [SLOTS];
    logic        tbl_is_seat [SLOTS];
    logic [15:0] tbl_dest [SLOTS];
    logic [15:0] tbl_ref [SLOTS];
    logic [9:0]  tbl_len [SLOTS];
    logic [31:0] tbl_last_seq;
    logic [31:0] tbl_now;

    t_item   pending_items [$];
    t_result expected_results [$];
    int      errors;
    int      sends_seen;
    int      results_seen;
    int      cycles;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_off;

    retransmit_slot_table_unit i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_command(in_item.command), .i_payload_length(in_item.length),
        .i_payload_ref(in_item.pref), .i_dest_is_seat(in_item.is_seat),
        .i_dest_id(in_item.dest), .i_ack_seq(in_item.ack_seq),
        .i_peer_present_mask(in_item.mask),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_kind(out_res.kind), .o_slot(out_res.slot), .o_seq_out(out_res.seq),
        .o_out_is_seat(out_res.is_seat), .o_out_dest(out_res.dest),
        .o_out_payload_ref(out_res.pref), .o_out_length(out_res.length),
        .o_ok(out_res.ok), .o_last(out_res.last)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic bit routable(logic is_seat, logic [15:0] dest, logic [15:0] mask);
        if (!is_seat)
            return 1'b1;
        if (dest >= MAX_SEATS)
            return 1'b0;
        return mask[dest[3:0]];
    endfunction

    function automatic t_result slot_result(logic [2:0] kind, int s, logic ok);
        t_result r;
        r = '0;
        r.kind = kind;
        r.slot = s[5:0];
        r.seq = tbl_seq[s];
        r.is_seat = tbl_is_seat[s];
        r.dest = tbl_dest[s];
        r.pref = tbl_ref[s];
        r.length = tbl_len[s];
        r.ok = ok;
        return r;
    endfunction

    task automatic table_reset();
        tbl_interval = 16'd220;
        tbl_max_tries = 8'd16;
        tbl_max_len = 10'd599;
        for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        tbl_last_seq = '0;
        tbl_now = '0;
    endtask

    // expected results of one accepted transfer
    task automatic predict_table(t_item it);
        t_result rs [$];
        t_result r;
        int s;
        logic [31:0] sq;
        s = -1;
        r = '0;
        if (it.command == rst_pkg::CMD_QUEUE) begin
            if (it.length == 0 || it.length > tbl_max_len) begin
                r.kind = rst_pkg::KIND_QSTAT;
                rs.push_back(r);
            end else begin
                sq = tbl_last_seq + 1;
                if (sq == 0)
                    sq = 1;
                tbl_last_seq = sq;
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && !tbl_valid[i])
                        s = i;
                if (s < 0)
                    s = int'(sq % 32'(SLOTS));
                tbl_valid[s] = 1'b1;
                tbl_seq[s] = sq;
                tbl_is_seat[s] = it.is_seat;
                tbl_dest[s] = it.dest;
                tbl_ref[s] = it.pref;
                tbl_len[s] = it.length;
                if (routable(it.is_seat, it.dest, it.mask)) begin
                    tbl_tries[s] = 8'd1;
                    tbl_due[s] = tbl_now + tbl_interval;
                    rs.push_back(slot_result(rst_pkg::KIND_SEND, s, 1'b0));
                    rs.push_back(slot_result(rst_pkg::KIND_QSTAT, s, 1'b1));
                end else begin
                    tbl_tries[s] = 8'd0;
                    tbl_due[s] = tbl_now;
                    rs.push_back(slot_result(rst_pkg::KIND_QSTAT, s, 1'b0));
                end
            end
        end else if (it.command == rst_pkg::CMD_ACK) begin
            for (int i = 0; i < SLOTS; i++)
                if (s < 0 && tbl_valid[i] && tbl_seq[i] == it.ack_seq)
                    s = i;
            if (s >= 0) begin
                tbl_valid[s] = 1'b0;
                rs.push_back(slot_result(rst_pkg::KIND_ASTAT, s, 1'b1));
            end else begin
                r.kind = rst_pkg::KIND_ASTAT;
                r.seq = it.ack_seq;
                rs.push_back(r);
            end
        end else if (it.command == rst_pkg::CMD_TICK) begin
            tbl_now = tbl_now + 1;
            for (int i = 0; i < SLOTS; i++) begin
                sq = tbl_now - tbl_due[i];
                if (tbl_valid[i] && !sq[31]) begin
                    if (!routable(tbl_is_seat[i], tbl_dest[i], it.mask)) begin
                        tbl_valid[i] = 1'b0;
                        rs.push_back(slot_result(rst_pkg::KIND_NOROUTE, i, 1'b0));
                    end else if (tbl_tries[i] >= tbl_max_tries) begin
                        tbl_valid[i] = 1'b0;
                        rs.push_back(slot_result(rst_pkg::KIND_GAVEUP, i, 1'b0));
                    end else begin
                        tbl_tries[i] = tbl_tries[i] + 8'd1;
                        tbl_due[i] = tbl_now + tbl_interval;
                        rs.push_back(slot_result(rst_pkg::KIND_SEND, i, 1'b0));
                    end
                end
            end
            r.kind = rst_pkg::KIND_TDONE;
            rs.push_back(r);
        end
        if (rs.size() > 0) begin
            rs[rs.size() - 1].last = 1'b1;
            foreach (rs[k])
                expected_results.push_back(rs[k]);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid)
                predict_table(in_item);
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_item <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver hold-off countdown
    always @(posedge clk) begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // monitor and receiver
    always @(posedge clk) begin
        t_result want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL retransmit_slot_table_unit");
            $finish;
        end
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (out_res.kind == rst_pkg::KIND_SEND)
                sends_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result kind", 32'(out_res.kind), 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (out_res.kind != want.kind)
                    report_mismatch("kind", 32'(out_res.kind), 32'(want.kind));
                if (out_res.slot != want.slot)
                    report_mismatch("slot", 32'(out_res.slot), 32'(want.slot));
                if (out_res.seq != want.seq) report_mismatch("seq", out_res.seq, want.seq);
                if (out_res.is_seat != want.is_seat)
                    report_mismatch("is_seat", 32'(out_res.is_seat), 32'(want.is_seat));
                if (out_res.dest != want.dest)
                    report_mismatch("dest", 32'(out_res.dest), 32'(want.dest));
                if (out_res.pref != want.pref)
                    report_mismatch("ref", 32'(out_res.pref), 32'(want.pref));
                if (out_res.length != want.length)
                    report_mismatch("length", 32'(out_res.length), 32'(want.length));
                if (out_res.ok != want.ok)
                    report_mismatch("ok", 32'(out_res.ok), 32'(want.ok));
                if (out_res.last != want.last)
                    report_mismatch("last", 32'(out_res.last), 32'(want.last));
            end
        end
        if (hold_off > 0) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_item rand_item();
        t_item it;
        it.command = 2'($urandom_range(2));
        it.length = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1, 40));
        it.pref = 16'($urandom);
        it.is_seat = 1'($urandom);
        it.dest = ($urandom_range(3) == 0) ? 16'($urandom)
                : 16'($urandom_range(MAX_SEATS - 1));
        it.ack_seq = ($urandom_range(7) == 0) ? $urandom
                   : tbl_last_seq - $urandom_range(60);
        it.mask = ($urandom_range(3) == 0) ? 16'($urandom) : 16'hffff;
        if ($urandom_range(40) == 0)
            it.command = 2'd3;
        return it;
    endfunction

    task automatic queue_item(logic [1:0] c, logic [9:0] l, logic s, logic [15:0] d,
                              logic [31:0] a, logic [15:0] m);
        t_item it;
        it.command = c;
        it.length = l;
        it.pref = 16'($urandom);
        it.is_seat = s;
        it.dest = d;
        it.ack_seq = a;
        it.mask = m;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        // ignored commands may leave nothing to wait on
        repeat (SLOTS * 3 + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == rst_pkg::REG_INTERVAL) tbl_interval = val;
        else if (idx == rst_pkg::REG_TRIES) tbl_max_tries = val[7:0];
        else if (idx == rst_pkg::REG_PAYLOAD) tbl_max_len = val[9:0];
    endtask

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            pending_items.push_back(rand_item());
            if (pending_items.size() > 8)
                @(posedge clk);
        end
        drain();
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = rst_pkg::REG_INTERVAL;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        errors = 0;
        cycles = 0;
        sends_seen = 0;
        results_seen = 0;
        hold_off = 0;
        send_idle_pct = 31;
        recv_idle_pct = 78;
        table_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(rst_pkg::REG_INTERVAL, 16'd2);
        write_reg(rst_pkg::REG_TRIES, 16'd3);
        // directed: length extremes, routes, acks, ticks, unused command
        queue_item(rst_pkg::CMD_QUEUE, 10'd0, 1'b0, 16'd5, 32'd0, 16'h0000);
        queue_item(rst_pkg::CMD_QUEUE, 10'd599, 1'b0, 16'hffff, 32'd0, 16'h0000);
        queue_item(rst_pkg::CMD_QUEUE, 10'd600, 1'b0, 16'd1, 32'd0, 16'hffff);
        queue_item(rst_pkg::CMD_QUEUE, 10'd1, 1'b1, 16'd15, 32'd0, 16'h8000);
        queue_item(rst_pkg::CMD_QUEUE, 10'd3, 1'b1, 16'd16, 32'd0, 16'hffff);
        queue_item(rst_pkg::CMD_QUEUE, 10'd3, 1'b1, 16'd2, 32'd0, 16'h0000);
        queue_item(rst_pkg::CMD_ACK, 10'd0, 1'b0, 16'd0, 32'd0, 16'd0);
        queue_item(rst_pkg::CMD_ACK, 10'd0, 1'b0, 16'd0, 32'hffffffff, 16'd0);
        queue_item(rst_pkg::CMD_ACK, 10'd0, 1'b0, 16'd0, 32'd2, 16'd0);
        queue_item(rst_pkg::CMD_TICK, 10'd0, 1'b0, 16'd0, 32'd0, 16'h0000);
        queue_item(2'd3, 10'h3ff, 1'b1, 16'hffff, 32'hffffffff, 16'hffff);
        for (int i = 0; i < 8; i++)
            queue_item(rst_pkg::CMD_TICK, 10'd0, 1'b0, 16'd0, 32'd0, 16'hffff);
        drain();

        // fill the table past full so slots get overwritten
        write_reg(rst_pkg::REG_PAYLOAD, 16'd1023);
        write_reg(rst_pkg::REG_INTERVAL, 16'd65535);
        for (int i = 0; i < SLOTS + 6; i++)
            queue_item(rst_pkg::CMD_QUEUE, 10'h3ff, 1'b0, 16'($urandom), 32'd0, 16'd0);
        queue_item(rst_pkg::CMD_TICK, 10'd0, 1'b0, 16'd0, 32'd0, 16'hffff);
        drain();
        for (int i = 0; i < SLOTS + 6; i++)
            queue_item(rst_pkg::CMD_ACK, 10'd0, 1'b0, 16'd0, 32'd60 - 32'(i), 16'd0);
        drain();

        write_reg(rst_pkg::REG_INTERVAL, 16'd3);
        write_reg(rst_pkg::REG_TRIES, 16'd255);
        write_reg(rst_pkg::REG_PAYLOAD, 16'd1);
        random_phase(30);
        write_reg(rst_pkg::REG_TRIES, 16'd1);
        write_reg(rst_pkg::REG_PAYLOAD, 16'd700);
        write_reg(rst_pkg::REG_INTERVAL, 16'd1);
        random_phase(70);

        send_idle_pct = 78;
        recv_idle_pct = 31;
        write_reg(rst_pkg::REG_INTERVAL, 16'd5);
        write_reg(rst_pkg::REG_TRIES, 16'd4);
        // long receiver stall while the sender keeps offering
        hold_off = 400;
        random_phase(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(rst_pkg::REG_INTERVAL, 16'd2);
        write_reg(rst_pkg::REG_TRIES, 16'd16);
        random_phase(100);

        $display("covered %0d results, %0d sends over several register settings",
                 results_seen, sends_seen);
        if (errors == 0)
            $display("PASS retransmit_slot_table_unit");
        else
            $display("FAIL retransmit_slot_table_unit");
        $finish;
    end
endmodule
